/* rtl/mbrot_pkg.sv */
package mbrot_pkg;

  localparam int COORD_W       = 32;
  localparam int FRACTION_BITS = 28;
  localparam int PIXEL_W       = 12;
  localparam int STEP_W        = 31;
  localparam int COUNT_W       = 16;
  localparam int MAG_W         = 32;
  localparam int RADIUS_SQ     = 4;

  // Multiplier chain: one digit of the second operand per cell, most significant first.
  localparam int DIGIT_W   = 8;
  localparam int NUM_CELLS = COORD_W / DIGIT_W;
  localparam int PROD_W    = 2 * COORD_W;

  // The cross product keeps one more bit since 2*re*im drops one fraction bit fewer.
  localparam int CROSS_W   = PROD_W - FRACTION_BITS + 1;
  localparam int SQ_W      = PROD_W - FRACTION_BITS;
  localparam int XPROD_W   = PIXEL_W + STEP_W;
  localparam int WIDE_W    = XPROD_W + 3;
  localparam int MAG_SHIFT = FRACTION_BITS - 24;

  localparam logic [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(RADIUS_SQ) << FRACTION_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COORD_W-1:0] TOP_LEFT_REAL_RESET   = 32'hD000_0000;
  localparam logic [COORD_W-1:0] TOP_LEFT_IMAG_RESET   = 32'h2199_999A;
  localparam logic [STEP_W-1:0]  STEP_RESET            = 31'd1610613;
  localparam logic [COUNT_W-1:0] ITERATION_LIMIT_RESET = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_LEFT_REAL   = 3'd0,
    CFG_TOP_LEFT_IMAG   = 3'd1,
    CFG_REAL_STEP       = 3'd2,
    CFG_IMAG_STEP       = 3'd3,
    CFG_ITERATION_LIMIT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PROD_CROSS = 2'd0,
    PROD_RE_SQ = 2'd1,
    PROD_IM_SQ = 2'd2
  } prod_kind_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
  } mbrot_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_x;
    logic [PIXEL_W-1:0] out_y;
    logic [COUNT_W-1:0] iterations;
    logic               escaped;
    logic [MAG_W-1:0]   magnitude_sq;
  } mbrot_out_t;

  // One beat travelling down the multiplier chain.
  typedef struct packed {
    logic               valid;
    prod_kind_e         kind;
    logic               neg;
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic [PROD_W-1:0]  acc;
  } mul_beat_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_W:0] upper;
    logic [COORD_W-1:0]      r;
    upper = v[WIDE_W-1:COORD_W-1];
    if ((&upper) || !(|upper)) begin
      r = v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] abs_coord(input logic [COORD_W-1:0] v);
    return v[COORD_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

/* rtl/mbrot_mul_cell.sv */
module mbrot_mul_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  mbrot_pkg::mul_beat_t  prev,
  output mbrot_pkg::mul_beat_t  next
);
  import mbrot_pkg::*;

  logic [COORD_W+DIGIT_W-1:0] part;
  logic [PROD_W-1:0]          acc_next;

  // Horner step: shift the running sum up one digit and add a times the top digit of b.
  always_comb begin
    part     = (COORD_W + DIGIT_W)'(prev.a) * (COORD_W + DIGIT_W)'(prev.b[COORD_W-1 -: DIGIT_W]);
    acc_next = {prev.acc[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(part);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= prev.valid;
    end
    next.kind <= prev.kind;
    next.neg  <= prev.neg;
    next.a    <= prev.a;
    next.b    <= {prev.b[COORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    next.acc  <= acc_next;
  end

endmodule

/* rtl/mbrot_mul_chain.sv */
module mbrot_mul_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  mbrot_pkg::mul_beat_t  head,
  output mbrot_pkg::mul_beat_t  tail
);
  import mbrot_pkg::*;

  mul_beat_t stage [NUM_CELLS+1];

  assign stage[0] = head;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mbrot_mul_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (stage[g]),
      .next (stage[g+1])
    );
  end

  assign tail = stage[NUM_CELLS];

endmodule

/* rtl/mandelbrot_escape_time.sv */
// Mandelbrot escape-time unit.
// Pixel channel (pixel_valid / pixel_stall / pixel): a beat is taken when valid is high
// and stall is low. The unit works on one pixel at a time; pixel_stall is high from the
// beat it takes until its result has been loaded into the output register.
// Result channel (result_valid / result_stall / result): one beat per pixel, in order.
// The result sits in an output register, so the next pixel is taken while an earlier
// result is still stalled; a finished pixel waits only if that register is still full.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; writes are meant to happen only while no pixel is in flight, and
// indexes beyond the register list are ignored.
// Sequence: the point c is formed first; then each iteration updates re and im, issues
// re*im, re*re and im*im into the four-cell multiplier chain and waits for the last
// product to leave the chain. The unit takes no new pixel while one is in flight: the
// next pixel beat is taken in the cycle after the previous result is loaded into the
// output register.
// Reset (rst, synchronous) empties the unit and the output register and loads the
// default view and an iteration limit of 256.
module mandelbrot_escape_time (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  mbrot_pkg::mbrot_in_t                 pixel,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output mbrot_pkg::mbrot_out_t                result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbrot_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbrot_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_COORD  = 6'b000010,
    S_CHECK  = 6'b000100,
    S_ISSUE  = 6'b001000,
    S_WAIT   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [COORD_W-1:0] top_left_real;
  logic [COORD_W-1:0] top_left_imag;
  logic [STEP_W-1:0]  real_step;
  logic [STEP_W-1:0]  imag_step;
  logic [COUNT_W-1:0] iteration_limit;

  logic [PIXEL_W-1:0] px;
  logic [PIXEL_W-1:0] py;
  logic [XPROD_W-1:0] xprod;
  logic [XPROD_W-1:0] yprod;
  logic [COORD_W-1:0] c_re;
  logic [COORD_W-1:0] c_im;
  logic [COORD_W-1:0] re;
  logic [COORD_W-1:0] im;
  logic [SQ_W-1:0]    re2;
  logic [SQ_W-1:0]    im2;
  logic [CROSS_W-1:0] cross_prod;
  logic               cross_neg;
  logic [COUNT_W-1:0] count;
  prod_kind_e         issue_kind;

  mul_beat_t          issue_beat;
  mul_beat_t          chain_out;

  logic [WIDE_W-1:0]  c_re_wide;
  logic [WIDE_W-1:0]  c_im_wide;
  logic [WIDE_W-1:0]  cross_ext;
  logic [WIDE_W-1:0]  cross_sgn;
  logic [WIDE_W-1:0]  im_wide;
  logic [WIDE_W-1:0]  re_wide;
  logic [SQ_W:0]      mag_sum;
  logic [MAG_W-1:0]   mag_out;
  logic               keep_going;

  assign pixel_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;

  always_comb begin
    c_re_wide = {{(WIDE_W-COORD_W){top_left_real[COORD_W-1]}}, top_left_real}
              + {{(WIDE_W-XPROD_W){1'b0}}, xprod};
    c_im_wide = {{(WIDE_W-COORD_W){top_left_imag[COORD_W-1]}}, top_left_imag}
              - {{(WIDE_W-XPROD_W){1'b0}}, yprod};

    cross_ext = {{(WIDE_W-CROSS_W){1'b0}}, cross_prod};
    cross_sgn = cross_neg ? (~cross_ext + 1'b1) : cross_ext;
    im_wide   = cross_sgn + {{(WIDE_W-COORD_W){c_im[COORD_W-1]}}, c_im};
    re_wide   = {{(WIDE_W-SQ_W){1'b0}}, re2} - {{(WIDE_W-SQ_W){1'b0}}, im2}
              + {{(WIDE_W-COORD_W){c_re[COORD_W-1]}}, c_re};

    mag_sum    = {1'b0, re2} + {1'b0, im2};
    keep_going = (mag_sum <= ESCAPE_LIMIT) && (count < iteration_limit);
    if (|mag_sum[SQ_W:MAG_SHIFT+MAG_W]) begin
      mag_out = {MAG_W{1'b1}};
    end else begin
      mag_out = mag_sum[MAG_SHIFT +: MAG_W];
    end
  end

  // The three products of one iteration enter the chain on consecutive cycles.
  always_comb begin
    issue_beat.valid = (state == S_ISSUE);
    issue_beat.kind  = issue_kind;
    issue_beat.acc   = '0;
    case (issue_kind)
      PROD_CROSS: begin
        issue_beat.neg = re[COORD_W-1] ^ im[COORD_W-1];
        issue_beat.a   = abs_coord(re);
        issue_beat.b   = abs_coord(im);
      end
      PROD_RE_SQ: begin
        issue_beat.neg = 1'b0;
        issue_beat.a   = abs_coord(re);
        issue_beat.b   = abs_coord(re);
      end
      default: begin
        issue_beat.neg = 1'b0;
        issue_beat.a   = abs_coord(im);
        issue_beat.b   = abs_coord(im);
      end
    endcase
  end

  mbrot_mul_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .head (issue_beat),
    .tail (chain_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      result_valid    <= 1'b0;
      issue_kind      <= PROD_CROSS;
      top_left_real   <= TOP_LEFT_REAL_RESET;
      top_left_imag   <= TOP_LEFT_IMAG_RESET;
      real_step       <= STEP_RESET;
      imag_step       <= STEP_RESET;
      iteration_limit <= ITERATION_LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOP_LEFT_REAL:   top_left_real   <= cfg_data[COORD_W-1:0];
          CFG_TOP_LEFT_IMAG:   top_left_imag   <= cfg_data[COORD_W-1:0];
          CFG_REAL_STEP:       real_step       <= cfg_data[STEP_W-1:0];
          CFG_IMAG_STEP:       imag_step       <= cfg_data[STEP_W-1:0];
          CFG_ITERATION_LIMIT: iteration_limit <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      // A beat leaving the output register frees it unless a new result moves in.
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end

      // Products leave the chain in issue order; the imaginary square comes last.
      if (chain_out.valid) begin
        case (chain_out.kind)
          PROD_CROSS: begin
            cross_prod <= chain_out.acc[PROD_W-1:FRACTION_BITS-1];
            cross_neg  <= chain_out.neg;
          end
          PROD_RE_SQ: re2 <= chain_out.acc[PROD_W-1:FRACTION_BITS];
          PROD_IM_SQ: im2 <= chain_out.acc[PROD_W-1:FRACTION_BITS];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (pixel_valid) begin
            px    <= pixel.pixel_x;
            py    <= pixel.pixel_y;
            xprod <= XPROD_W'(pixel.pixel_x) * XPROD_W'(real_step);
            yprod <= XPROD_W'(pixel.pixel_y) * XPROD_W'(imag_step);
            state <= S_COORD;
          end
        end
        S_COORD: begin
          c_re       <= sat_coord(c_re_wide);
          c_im       <= sat_coord(c_im_wide);
          re2        <= '0;
          im2        <= '0;
          cross_prod <= '0;
          cross_neg  <= 1'b0;
          count      <= '0;
          state      <= S_CHECK;
        end
        S_CHECK: begin
          if (keep_going) begin
            im         <= sat_coord(im_wide);
            re         <= sat_coord(re_wide);
            count      <= count + 1'b1;
            issue_kind <= PROD_CROSS;
            state      <= S_ISSUE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_ISSUE: begin
          case (issue_kind)
            PROD_CROSS: issue_kind <= PROD_RE_SQ;
            PROD_RE_SQ: issue_kind <= PROD_IM_SQ;
            default: begin
              issue_kind <= PROD_CROSS;
              state      <= S_WAIT;
            end
          endcase
        end
        S_WAIT: begin
          if (chain_out.valid && (chain_out.kind == PROD_IM_SQ)) begin
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid        <= 1'b1;
            result.out_x        <= px;
            result.out_y        <= py;
            result.iterations   <= count;
            result.escaped      <= (count < iteration_limit);
            result.magnitude_sq <= mag_out;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
